FILE: src/ttcpq_pkg.sv
package ttcpq_pkg;

  // Width of the frame capacity register and its reset value
  localparam int unsigned CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Share phase: data gets the turn at phase zero, one turn in ten
  localparam int unsigned PHASE_W = 4;
  localparam logic [PHASE_W-1:0] PHASE_DATA = 4'd0;
  localparam logic [PHASE_W-1:0] PHASE_LAST = 4'd9;

  // Function codes of an input beat
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Source queue codes
  localparam logic [1:0] CLASS_CONTROL = 2'd0;
  localparam logic [1:0] CLASS_HEADER  = 2'd1;
  localparam logic [1:0] CLASS_DATA    = 2'd2;

  // Stored packet descriptor
  typedef struct packed {
    logic        pull;
    logic        header;
    logic [13:0] length;
    logic [15:0] id;
  } desc_t;

  typedef struct packed {
    logic        func;
    logic [15:0] packet_id;
    logic [13:0] packet_length;
    logic        ack_mark;
    logic        syn_mark;
    logic        nack_mark;
    logic        header_mark;
    logic        pull_mark;
  } in_item_t;

  typedef struct packed {
    logic        deq_valid;
    logic [15:0] deq_packet_id;
    logic [13:0] deq_length;
    logic        deq_is_header;
    logic        deq_is_pull;
    logic [1:0]  deq_class;
    logic        enq_trimmed;
    logic        enq_dropped;
    logic [31:0] trimmed_total;
    logic        all_empty;
  } out_item_t;

endpackage

FILE: src/trimming_three_class_packet_queue_unit.sv
// Trimming packet queue for one switch output port.
// The input channel (in_valid_i / in_stall_o / in_item_i) carries one beat per
// command: an enqueue of a packet descriptor or a dequeue request. Every beat
// gives exactly one result beat on the output channel (out_valid_o /
// out_stall_i / out_item_o).
// Control packets go to the control queue, headers and pulls to the header
// queue, data to the data queue until its fill reaches frame_capacity; past
// that, data packets are trimmed to headers. Dequeue serves control first,
// then shares header and data nine to one.
// An enqueue or a dequeue from empty queues has its result registered at the
// accept edge. A dequeue that pops first reads the descriptor memories through
// their registered read ports, then registers the result; the input stalls
// during the read cycle.
// The output register lets a new beat in while the previous result is taken;
// while the receiver stalls a held result, the input stalls as well.
// The cfg channel, always ready, writes the capacity register; the user must
// write it only while the queue is idle, not enforced. Reset empties all queues,
// clears trim count and share phase, sets capacity 64; memory needs no clearing.
module trimming_three_class_packet_queue_unit #(
  parameter int unsigned ControlDepth = 16,
  parameter int unsigned HeaderDepth  = 64,
  parameter int unsigned DataDepth    = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  ttcpq_pkg::in_item_t               in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output ttcpq_pkg::out_item_t              out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ttcpq_pkg::CAP_W-1:0]       cfg_data_i
);

  localparam int unsigned CtlPtrW  = $clog2(ControlDepth);
  localparam int unsigned CtlFillW = $clog2(ControlDepth + 1);
  localparam int unsigned HdrPtrW  = $clog2(HeaderDepth);
  localparam int unsigned HdrFillW = $clog2(HeaderDepth + 1);
  localparam int unsigned DatPtrW  = $clog2(DataDepth);
  localparam int unsigned DatFillW = $clog2(DataDepth + 1);
  localparam int unsigned CmpW     = (DatFillW > ttcpq_pkg::CAP_W) ?
                                     DatFillW : ttcpq_pkg::CAP_W;

  // Queue status
  logic [CtlPtrW-1:0]  ctl_head, ctl_tail;
  logic [CtlFillW-1:0] ctl_fill;
  logic [HdrPtrW-1:0]  hdr_head, hdr_tail;
  logic [HdrFillW-1:0] hdr_fill;
  logic [DatPtrW-1:0]  dat_head, dat_tail;
  logic [DatFillW-1:0] dat_fill;
  logic ctl_full, ctl_empty, hdr_full, hdr_empty, dat_full, dat_empty;

  logic ctl_push, ctl_pop, hdr_push, hdr_pop, dat_push, dat_pop;
  ttcpq_pkg::desc_t ctl_rdata, hdr_rdata, dat_rdata;
  ttcpq_pkg::desc_t enq_word, hdr_wdata;

  // Control state
  logic [ttcpq_pkg::CAP_W-1:0]   cap_q;
  logic [ttcpq_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [31:0]                   trim_q, trim_d;
  logic                          pend_q;
  logic [1:0]                    pend_class_q, deq_class;
  logic                          out_valid_q;
  ttcpq_pkg::out_item_t          out_q, out_d;
  logic                          out_load;

  logic accept, is_enq, is_ctl, is_hdr, trim_cond, enq_ok, enq_trim;
  logic deq_hit;
  ttcpq_pkg::desc_t pend_word;

  // Input beat is taken when no read is in flight and the output slot frees
  assign in_stall_o  = pend_q | (out_valid_q & out_stall_i);
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Empty flags from the fill counts
  assign ctl_empty = (ctl_fill == '0);
  assign hdr_empty = (hdr_fill == '0);
  assign dat_empty = (dat_fill == '0);

  // Classify the enqueued packet
  assign is_enq    = (in_item_i.func == ttcpq_pkg::FUNC_ENQ);
  assign is_ctl    = in_item_i.ack_mark | in_item_i.syn_mark | in_item_i.nack_mark;
  assign is_hdr    = in_item_i.header_mark | in_item_i.pull_mark;
  assign trim_cond = (CmpW'(dat_fill) >= CmpW'(cap_q));

  assign enq_word = '{pull:   in_item_i.pull_mark,
                      header: in_item_i.header_mark,
                      length: in_item_i.packet_length,
                      id:     in_item_i.packet_id};

  // Route the enqueue and pick the dequeue source
  always_comb begin
    ctl_push  = 1'b0;
    hdr_push  = 1'b0;
    dat_push  = 1'b0;
    ctl_pop   = 1'b0;
    hdr_pop   = 1'b0;
    dat_pop   = 1'b0;
    enq_ok    = 1'b0;
    enq_trim  = 1'b0;
    hdr_wdata = enq_word;
    deq_hit   = 1'b0;
    deq_class = ttcpq_pkg::CLASS_CONTROL;
    phase_d   = phase_q;
    trim_d    = trim_q;
    if (accept && is_enq) begin
      if (is_ctl) begin
        enq_ok   = ~ctl_full;
        ctl_push = ~ctl_full;
      end else if (is_hdr) begin
        enq_ok   = ~hdr_full;
        hdr_push = ~hdr_full;
      end else if (trim_cond) begin
        // Trim to a bare header
        hdr_wdata = '{pull: 1'b0, header: 1'b1, length: '0, id: in_item_i.packet_id};
        enq_ok    = ~hdr_full;
        hdr_push  = ~hdr_full;
        enq_trim  = ~hdr_full;
        trim_d    = trim_q + {31'd0, ~hdr_full};
      end else begin
        enq_ok   = ~dat_full;
        dat_push = ~dat_full;
      end
    end else if (accept) begin
      if (!ctl_empty) begin
        deq_hit   = 1'b1;
        ctl_pop   = 1'b1;
        deq_class = ttcpq_pkg::CLASS_CONTROL;
      end else if (!hdr_empty && !dat_empty) begin
        deq_hit = 1'b1;
        if (phase_q == ttcpq_pkg::PHASE_DATA) begin
          dat_pop   = 1'b1;
          deq_class = ttcpq_pkg::CLASS_DATA;
        end else begin
          hdr_pop   = 1'b1;
          deq_class = ttcpq_pkg::CLASS_HEADER;
        end
        phase_d = (phase_q == ttcpq_pkg::PHASE_LAST) ? '0 : phase_q + 1'b1;
      end else if (!dat_empty) begin
        deq_hit   = 1'b1;
        dat_pop   = 1'b1;
        deq_class = ttcpq_pkg::CLASS_DATA;
      end else if (!hdr_empty) begin
        deq_hit   = 1'b1;
        hdr_pop   = 1'b1;
        deq_class = ttcpq_pkg::CLASS_HEADER;
      end
    end
  end

  // Pointer and fill tracking per queue
  ttcpq_ptr #(.Depth(ControlDepth)) u_ctl_ptr (
    .clk_i, .rst_ni, .push_i(ctl_push), .pop_i(ctl_pop),
    .head_o(ctl_head), .tail_o(ctl_tail), .fill_o(ctl_fill),
    .full_o(ctl_full)
  );

  ttcpq_ptr #(.Depth(HeaderDepth)) u_hdr_ptr (
    .clk_i, .rst_ni, .push_i(hdr_push), .pop_i(hdr_pop),
    .head_o(hdr_head), .tail_o(hdr_tail), .fill_o(hdr_fill),
    .full_o(hdr_full)
  );

  ttcpq_ptr #(.Depth(DataDepth)) u_dat_ptr (
    .clk_i, .rst_ni, .push_i(dat_push), .pop_i(dat_pop),
    .head_o(dat_head), .tail_o(dat_tail), .fill_o(dat_fill),
    .full_o(dat_full)
  );

  // Descriptor memories
  ttcpq_ram #(.Depth(ControlDepth)) u_ctl_ram (
    .clk_i, .we_i(ctl_push), .waddr_i(ctl_tail), .wdata_i(enq_word),
    .re_i(ctl_pop), .raddr_i(ctl_head), .rdata_o(ctl_rdata)
  );

  ttcpq_ram #(.Depth(HeaderDepth)) u_hdr_ram (
    .clk_i, .we_i(hdr_push), .waddr_i(hdr_tail), .wdata_i(hdr_wdata),
    .re_i(hdr_pop), .raddr_i(hdr_head), .rdata_o(hdr_rdata)
  );

  ttcpq_ram #(.Depth(DataDepth)) u_dat_ram (
    .clk_i, .we_i(dat_push), .waddr_i(dat_tail), .wdata_i(enq_word),
    .re_i(dat_pop), .raddr_i(dat_head), .rdata_o(dat_rdata)
  );

  // Select the read data of the pending pop
  always_comb begin
    case (pend_class_q)
      ttcpq_pkg::CLASS_CONTROL: pend_word = ctl_rdata;
      ttcpq_pkg::CLASS_HEADER:  pend_word = hdr_rdata;
      ttcpq_pkg::CLASS_DATA:    pend_word = dat_rdata;
      default:                  pend_word = dat_rdata;
    endcase
  end

  // Build the next result beat
  always_comb begin
    out_d          = '0;
    out_load       = 1'b0;
    out_d.trimmed_total = trim_d;
    if (pend_q) begin
      out_load             = 1'b1;
      out_d.deq_valid      = 1'b1;
      out_d.deq_packet_id  = pend_word.id;
      out_d.deq_length     = pend_word.length;
      out_d.deq_is_header  = pend_word.header;
      out_d.deq_is_pull    = pend_word.pull;
      out_d.deq_class      = pend_class_q;
      out_d.all_empty      = ctl_empty & hdr_empty & dat_empty;
    end else if (accept && is_enq) begin
      // Queues are never all empty after an enqueue: a drop means a full target
      out_load          = 1'b1;
      out_d.enq_trimmed = enq_trim;
      out_d.enq_dropped = ~enq_ok;
      out_d.all_empty   = 1'b0;
    end else if (accept && !deq_hit) begin
      out_load        = 1'b1;
      out_d.all_empty = 1'b1;
    end
  end

  // Hold control state, the pending read and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= ttcpq_pkg::CAP_RESET;
      phase_q      <= ttcpq_pkg::PHASE_DATA;
      trim_q       <= '0;
      pend_q       <= 1'b0;
      pend_class_q <= ttcpq_pkg::CLASS_CONTROL;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      phase_q <= phase_d;
      trim_q  <= trim_d;
      pend_q  <= deq_hit;
      if (deq_hit) begin
        pend_class_q <= deq_class;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: src/ttcpq_ram.sv
module ttcpq_ram #(
  parameter int unsigned Depth = 64
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Depth)-1:0]   waddr_i,
  input  ttcpq_pkg::desc_t           wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(Depth)-1:0]   raddr_i,
  output ttcpq_pkg::desc_t           rdata_o
);

  ttcpq_pkg::desc_t mem [Depth];
  ttcpq_pkg::desc_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/ttcpq_ptr.sv
module ttcpq_ptr #(
  parameter int unsigned Depth = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic                         pop_i,
  output logic [$clog2(Depth)-1:0]     head_o,
  output logic [$clog2(Depth)-1:0]     tail_o,
  output logic [$clog2(Depth+1)-1:0]   fill_o,
  output logic                         full_o
);

  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned FillW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0]  PtrLast  = PtrW'(Depth - 1);
  localparam logic [FillW-1:0] FillFull = FillW'(Depth);

  logic [PtrW-1:0]  head_q, head_d;
  logic [PtrW-1:0]  tail_q, tail_d;
  logic [FillW-1:0] fill_q, fill_d;

  // Advance pointers with wrap at the depth; push and pop never come together
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (push_i) begin
      tail_d = (tail_q == PtrLast) ? '0 : tail_q + 1'b1;
      fill_d = fill_q + 1'b1;
    end else if (pop_i) begin
      head_d = (head_q == PtrLast) ? '0 : head_q + 1'b1;
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  assign head_o  = head_q;
  assign tail_o  = tail_q;
  assign fill_o  = fill_q;
  assign full_o  = (fill_q == FillFull);

endmodule

FILE: test/trimming_three_class_packet_queue_unit_tb.sv
module trimming_three_class_packet_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CONTROL_DEPTH = 16;
  localparam int unsigned HEADER_DEPTH  = 64;
  localparam int unsigned DATA_DEPTH    = 64;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SHOWN_ERRORS  = 10;

  // Mark bits of an enqueue, ordered ack, syn, nack, header, pull
  localparam logic [4:0] MARK_NONE = 5'b00000;
  localparam logic [4:0] MARK_ACK  = 5'b10000;
  localparam logic [4:0] MARK_SYN  = 5'b01000;
  localparam logic [4:0] MARK_NACK = 5'b00100;
  localparam logic [4:0] MARK_HDR  = 5'b00010;
  localparam logic [4:0] MARK_PULL = 5'b00001;

  typedef enum logic {ROW_BEAT, ROW_CAP} row_kind_e;

  typedef struct {
    row_kind_e                   kind;
    ttcpq_pkg::in_item_t         item;
    logic                        pinned;
    ttcpq_pkg::out_item_t        pin;
    logic [ttcpq_pkg::CAP_W-1:0] cap;
  } script_row_t;

  typedef struct packed {
    logic                 on;
    ttcpq_pkg::out_item_t val;
  } pin_t;

  logic                        clk_i;
  logic                        rst_n       = 1'b0;
  logic                        in_valid    = 1'b0;
  logic                        in_stall;
  ttcpq_pkg::in_item_t         in_item     = '0;
  logic                        out_valid;
  logic                        out_stall   = 1'b0;
  ttcpq_pkg::out_item_t        out_item;
  logic                        cfg_valid   = 1'b0;
  logic                        cfg_ready;
  logic [ttcpq_pkg::CAP_W-1:0] cfg_data    = '0;

  // Shadow of the port queue
  ttcpq_pkg::desc_t              ctrl_q[$];
  ttcpq_pkg::desc_t              hdr_q[$];
  ttcpq_pkg::desc_t              data_q[$];
  logic [ttcpq_pkg::PHASE_W-1:0] share_phase = ttcpq_pkg::PHASE_DATA;
  logic [31:0]                   trim_total  = '0;
  logic [ttcpq_pkg::CAP_W-1:0]   frame_cap   = ttcpq_pkg::CAP_RESET;

  ttcpq_pkg::out_item_t pending_results[$];
  pin_t                 pinned_results[$];
  script_row_t          script[$];
  int unsigned          mismatches  = 0;
  int unsigned          cycles      = 0;
  logic                 calm        = 1'b0;

  trimming_three_class_packet_queue_unit #(
    .ControlDepth(CONTROL_DEPTH),
    .HeaderDepth (HEADER_DEPTH),
    .DataDepth   (DATA_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Apply one command to the shadow queue and return the result it gives
  function automatic ttcpq_pkg::out_item_t port_queue_step(ttcpq_pkg::in_item_t it);
    ttcpq_pkg::out_item_t r;
    ttcpq_pkg::desc_t     d;
    logic                 hq;
    logic                 dq;
    r = '0;
    if (it.func == ttcpq_pkg::FUNC_ENQ) begin
      d.id     = it.packet_id;
      d.length = it.packet_length;
      d.header = it.header_mark;
      d.pull   = it.pull_mark;
      if (it.ack_mark || it.syn_mark || it.nack_mark) begin
        if (ctrl_q.size() < CONTROL_DEPTH) ctrl_q.push_back(d);
        else r.enq_dropped = 1'b1;
      end else if (it.header_mark || it.pull_mark) begin
        if (hdr_q.size() < HEADER_DEPTH) hdr_q.push_back(d);
        else r.enq_dropped = 1'b1;
      end else if (data_q.size() >= int'(frame_cap)) begin
        // trim to a bare header
        d.length = '0;
        d.header = 1'b1;
        d.pull   = 1'b0;
        if (hdr_q.size() < HEADER_DEPTH) begin
          hdr_q.push_back(d);
          trim_total    = trim_total + 32'd1;
          r.enq_trimmed = 1'b1;
        end else begin
          r.enq_dropped = 1'b1;
        end
      end else begin
        if (data_q.size() < DATA_DEPTH) data_q.push_back(d);
        else r.enq_dropped = 1'b1;
      end
    end else begin
      hq = hdr_q.size() != 0;
      dq = data_q.size() != 0;
      r.deq_valid = 1'b1;
      if (ctrl_q.size() != 0) begin
        d           = ctrl_q.pop_front();
        r.deq_class = ttcpq_pkg::CLASS_CONTROL;
      end else if (hq && dq) begin
        // share header and data nine to one
        if (share_phase == ttcpq_pkg::PHASE_DATA) begin
          d           = data_q.pop_front();
          r.deq_class = ttcpq_pkg::CLASS_DATA;
        end else begin
          d           = hdr_q.pop_front();
          r.deq_class = ttcpq_pkg::CLASS_HEADER;
        end
        share_phase = (share_phase == ttcpq_pkg::PHASE_LAST) ?
                      ttcpq_pkg::PHASE_DATA : share_phase + 1'b1;
      end else if (dq) begin
        d           = data_q.pop_front();
        r.deq_class = ttcpq_pkg::CLASS_DATA;
      end else if (hq) begin
        d           = hdr_q.pop_front();
        r.deq_class = ttcpq_pkg::CLASS_HEADER;
      end else begin
        r.deq_valid = 1'b0;
      end
      if (r.deq_valid) begin
        r.deq_packet_id = d.id;
        r.deq_length    = d.length;
        r.deq_is_header = d.header;
        r.deq_is_pull   = d.pull;
      end
    end
    r.trimmed_total = trim_total;
    r.all_empty     = (ctrl_q.size() == 0) && (hdr_q.size() == 0) && (data_q.size() == 0);
    return r;
  endfunction

  function automatic ttcpq_pkg::in_item_t enq_item(logic [15:0] id, logic [13:0] len,
                                                    logic [4:0] marks);
    ttcpq_pkg::in_item_t it;
    it.func          = ttcpq_pkg::FUNC_ENQ;
    it.packet_id     = id;
    it.packet_length = len;
    {it.ack_mark, it.syn_mark, it.nack_mark, it.header_mark, it.pull_mark} = marks;
    return it;
  endfunction

  // Dequeue with junk in the unused fields
  function automatic ttcpq_pkg::in_item_t deq_item();
    ttcpq_pkg::in_item_t it;
    it      = enq_item(16'($urandom), 14'($urandom), 5'($urandom));
    it.func = ttcpq_pkg::FUNC_DEQ;
    return it;
  endfunction

  // Result of a beat that pops nothing
  function automatic ttcpq_pkg::out_item_t quiet_result(logic trimmed, logic [31:0] total,
                                                         logic empty);
    ttcpq_pkg::out_item_t r;
    r               = '0;
    r.enq_trimmed   = trimmed;
    r.trimmed_total = total;
    r.all_empty     = empty;
    return r;
  endfunction

  function automatic void add_beat(ttcpq_pkg::in_item_t it, logic pinned,
                                   ttcpq_pkg::out_item_t pin);
    script_row_t row;
    row.kind   = ROW_BEAT;
    row.item   = it;
    row.pinned = pinned;
    row.pin    = pin;
    row.cap    = '0;
    script.push_back(row);
  endfunction

  function automatic void add_cap(logic [ttcpq_pkg::CAP_W-1:0] cap);
    script_row_t row;
    row.kind   = ROW_CAP;
    row.item   = '0;
    row.pinned = 1'b0;
    row.pin    = '0;
    row.cap    = cap;
    script.push_back(row);
  endfunction

  // Random enqueue, weighted by class, with some fully random marks
  function automatic ttcpq_pkg::in_item_t random_enq(int unsigned ctrl_w, int unsigned hdr_w);
    int unsigned pick;
    logic [2:0]  ctl;
    logic [1:0]  hp;
    logic [4:0]  marks;
    logic [13:0] len;
    pick = $urandom_range(99);
    ctl  = 3'($urandom_range(7, 1));
    hp   = 2'($urandom_range(3, 1));
    if ($urandom_range(9) == 0) marks = 5'($urandom);
    else if (pick < ctrl_w) marks = {ctl, 2'($urandom)};
    else if (pick < ctrl_w + hdr_w) marks = {3'b000, hp};
    else marks = MARK_NONE;
    case ($urandom_range(7))
      0:       len = '0;
      1:       len = '1;
      default: len = 14'($urandom);
    endcase
    return enq_item(16'($urandom), len, marks);
  endfunction

  // Directed opening: extremes, every class, trimming, empty dequeues
  function automatic void build_script();
    add_beat(deq_item(), 1'b1, quiet_result(1'b0, 32'd0, 1'b1));
    add_beat(enq_item(16'hFFFF, 14'h3FFF, MARK_ACK | MARK_HDR | MARK_PULL), 1'b1,
             quiet_result(1'b0, 32'd0, 1'b0));
    add_beat(enq_item(16'h0000, 14'h0000, MARK_SYN), 1'b1, quiet_result(1'b0, 32'd0, 1'b0));
    add_beat(enq_item(16'h1234, 14'h0001, MARK_NACK), 1'b1, quiet_result(1'b0, 32'd0, 1'b0));
    add_beat(enq_item(16'hAAAA, 14'h2AAA, MARK_HDR), 1'b1, quiet_result(1'b0, 32'd0, 1'b0));
    add_beat(enq_item(16'h5555, 14'h1555, MARK_PULL), 1'b1, quiet_result(1'b0, 32'd0, 1'b0));
    add_beat(enq_item(16'h0F0F, 14'h0100, MARK_NONE), 1'b1, quiet_result(1'b0, 32'd0, 1'b0));
    repeat (7) add_beat(deq_item(), 1'b0, '0);
    add_cap('0);
    add_beat(enq_item(16'hBEEF, 14'h3FFF, MARK_NONE), 1'b1, quiet_result(1'b1, 32'd1, 1'b0));
    add_beat(enq_item(16'h0000, 14'h0000, MARK_ACK | MARK_SYN | MARK_NACK | MARK_HDR | MARK_PULL),
             1'b0, '0);
    repeat (3) add_beat(deq_item(), 1'b0, '0);
    add_cap('1);
  endfunction

  // Offer one beat; entered and left at a falling edge
  task automatic send_beat(ttcpq_pkg::in_item_t it, logic pinned, ttcpq_pkg::out_item_t pin);
    pin_t p;
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    p.on  = pinned;
    p.val = pin;
    pinned_results.push_back(p);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  // Hold the input idle until every result has been taken
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [ttcpq_pkg::CAP_W-1:0] cap);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk_i); while (!cfg_ready);
    frame_cap = cap;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Random receiver stall
  always @(negedge clk_i) begin
    out_stall <= !calm && ($urandom_range(99) < 12);
  end

  // Predict on every accepted command, check every accepted result
  always @(posedge clk_i) begin : monitor
    ttcpq_pkg::out_item_t want;
    pin_t                 p;
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = port_queue_step(in_item);
        p    = pinned_results.pop_front();
        pending_results.push_back(p.on ? p.val : want);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          if (mismatches < SHOWN_ERRORS)
            $display("unexpected result beat: %p", out_item);
          mismatches = mismatches + 1;
        end else begin
          want = pending_results.pop_front();
          if (out_item !== want) begin
            if (mismatches < SHOWN_ERRORS)
              $display("mismatch: expected %p got %p", want, out_item);
            mismatches = mismatches + 1;
          end
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int unsigned enq_pct[6];
    int unsigned ctrl_w[6];
    int unsigned hdr_w[6];
    logic [ttcpq_pkg::CAP_W-1:0] caps[6];
    build_script();
    repeat (9) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Walk the directed rows
    foreach (script[i]) begin
      if (script[i].kind == ROW_CAP) write_capacity(script[i].cap);
      else send_beat(script[i].item, script[i].pinned, script[i].pin);
    end

    // Random phases: fill and trim, overflow data, drain, overflow control, trim all, drain
    caps    = '{7'd64, 7'd127, 7'd0, 7'($urandom_range(63, 1)), 7'd0, 7'($urandom_range(127))};
    enq_pct = '{75, 80, 30, 85, 50, 20};
    ctrl_w  = '{15, 5, 20, 60, 20, 30};
    hdr_w   = '{25, 10, 30, 20, 30, 30};
    for (int ph = 0; ph < 6; ph++) begin
      write_capacity(caps[ph]);
      calm = (ph == 1);
      for (int n = 0; n < 130; n++) begin
        if ($urandom_range(99) < enq_pct[ph]) send_beat(random_enq(ctrl_w[ph], hdr_w[ph]), 1'b0, '0);
        else send_beat(deq_item(), 1'b0, '0);
      end
    end
    calm = 1'b0;

    wait_idle();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
